### src/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared types, character codes and heading name tables for the scanner.
// ----------------------------------------------------------------------------
package lhs_pkg;

    localparam int unsigned LINE_BITS_DEF  = 20;
    localparam int unsigned COL_BITS_DEF   = 16;
    localparam int unsigned DEPTH_BITS_DEF = 8;

    localparam int unsigned NUM_NAMES = 6;
    localparam int unsigned NAME_W    = 16;   // max characters held per name

    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_LBRK    = 8'd91;
    localparam logic [7:0] CH_BSLASH  = 8'd92;
    localparam logic [7:0] CH_RBRK    = 8'd93;
    localparam logic [7:0] CH_LBRACE  = 8'd123;
    localparam logic [7:0] CH_RBRACE  = 8'd125;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_NAME,
        PH_BRACKET,
        PH_AFTER_BRACKET,
        PH_TITLE,
        PH_IDLE
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_of_text;
    } t_in_word;

    // Names are right-justified: last character in the low byte.
    localparam logic [NAME_W*8-1:0] NAME_STR [NUM_NAMES] = '{
        (NAME_W*8)'("part"),
        (NAME_W*8)'("chapter"),
        (NAME_W*8)'("section"),
        (NAME_W*8)'("subsection"),
        (NAME_W*8)'("subsubsection"),
        (NAME_W*8)'("paragraph")
    };

    localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
        4'd4, 4'd7, 4'd7, 4'd10, 4'd13, 4'd9
    };

    // Character at position pos of name idx (valid only for pos < length).
    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [3:0] pos);
        logic [3:0] off;
        off = NAME_LEN[idx] - 4'd1 - pos;
        return NAME_STR[idx][{off, 3'b000} +: 8];
    endfunction

endpackage

### src/lhs_scan.sv
// ----------------------------------------------------------------------------
// lhs_scan
// Per-line scan state and next-state logic; one byte processed per fire.
// ----------------------------------------------------------------------------
module lhs_scan #(
    parameter int unsigned LINE_BITS  = lhs_pkg::LINE_BITS_DEF,
    parameter int unsigned COL_BITS   = lhs_pkg::COL_BITS_DEF,
    parameter int unsigned DEPTH_BITS = lhs_pkg::DEPTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  lhs_pkg::t_in_word     i_word,
    output logic                  o_emit,
    output logic [2:0]            o_level,
    output logic [LINE_BITS-1:0]  o_line_number,
    output logic [COL_BITS-1:0]   o_title_column,
    output logic [COL_BITS-1:0]   o_title_length,
    output logic                  o_unterminated,
    output logic                  o_overlong
);
    import lhs_pkg::*;

    t_phase                r_phase,   n_phase;
    logic [NUM_NAMES-1:0]  r_cand,    n_cand;
    logic [3:0]            r_pos,     n_pos;
    logic                  r_star,    n_star;
    logic [DEPTH_BITS-1:0] r_bracket, n_bracket;
    logic [DEPTH_BITS-1:0] r_brace,   n_brace;
    logic [COL_BITS-1:0]   r_col,     n_col;
    logic [COL_BITS-1:0]   r_tstart,  n_tstart;
    logic [COL_BITS-1:0]   r_tcount,  n_tcount;
    logic [LINE_BITS-1:0]  r_line,    n_line;
    logic [2:0]            r_level,   n_level;
    logic                  r_sat,     n_sat;

    logic [7:0]            c;
    logic                  col_full;
    logic [COL_BITS-1:0]   col_inc;
    logic                  tc_full;
    logic [COL_BITS-1:0]   tc_inc;
    logic                  is_letter;
    logic                  is_ws;
    logic                  hit;
    logic [2:0]            hit_level;
    logic [NUM_NAMES-1:0]  keep;

    assign c         = i_word.text_byte;
    assign col_full  = &r_col;
    assign col_inc   = col_full ? r_col : r_col + COL_BITS'(1);
    assign tc_full   = &r_tcount;
    assign tc_inc    = tc_full ? r_tcount : r_tcount + COL_BITS'(1);
    assign is_letter = c inside {[8'd65:8'd90], [8'd97:8'd122]};
    assign is_ws     = (c == CH_SPACE) || (c inside {[8'd9:8'd13]});

    // Name match on end of command: the later table entry wins.
    always_comb begin
        hit       = 1'b0;
        hit_level = '0;
        keep      = '0;
        for (int i = 0; i < NUM_NAMES; i++) begin
            if (r_cand[i] && NAME_LEN[i] == r_pos) begin
                hit       = 1'b1;
                hit_level = 3'(i);
            end
            if (r_cand[i] && r_pos < NAME_LEN[i] && name_char(3'(i), r_pos) == c) begin
                keep[i] = 1'b1;
            end
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_cand         = r_cand;
        n_pos          = r_pos;
        n_star         = r_star;
        n_bracket      = r_bracket;
        n_brace        = r_brace;
        n_col          = r_col;
        n_tstart       = r_tstart;
        n_tcount       = r_tcount;
        n_line         = r_line;
        n_level        = r_level;
        n_sat          = r_sat;
        o_emit         = 1'b0;
        o_level        = r_level;
        o_line_number  = r_line;
        o_title_column = r_tstart;
        o_title_length = r_tcount;
        o_unterminated = 1'b0;
        o_overlong     = r_sat;

        if (c == CH_NL) begin
            o_emit         = (r_phase == PH_TITLE) && (r_tcount != '0);
            o_unterminated = 1'b1;
            n_line         = (&r_line) ? r_line : r_line + LINE_BITS'(1);
            n_phase        = PH_LEAD;
            n_cand         = '1;
            n_pos          = '0;
            n_star         = 1'b0;
            n_bracket      = '0;
            n_brace        = '0;
            n_col          = '0;
            n_tstart       = '0;
            n_tcount       = '0;
            n_level        = '0;
            n_sat          = 1'b0;
        end else begin
            case (r_phase)
                PH_LEAD: begin
                    if (c == CH_BSLASH) begin
                        n_phase = PH_NAME;
                    end else if (!is_ws) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_NAME: begin
                    if (c == CH_STAR) begin
                        if (r_star) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_star = 1'b1;
                        end
                    end else if (!is_letter) begin
                        if (!hit) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_level = hit_level;
                            if (c == CH_LBRK) begin
                                n_bracket = DEPTH_BITS'(1);
                                n_phase   = PH_BRACKET;
                            end else if (c == CH_LBRACE) begin
                                n_brace  = DEPTH_BITS'(1);
                                n_tstart = col_inc;
                                n_sat    = r_sat | col_full;
                                n_phase  = PH_TITLE;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end else if (r_star) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_cand = keep;
                        n_pos  = (r_pos == 4'd15) ? r_pos : r_pos + 4'd1;
                        if (keep == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_BRACKET: begin
                    if (c == CH_LBRK) begin
                        if (&r_bracket) begin
                            n_sat = 1'b1;
                        end else begin
                            n_bracket = r_bracket + DEPTH_BITS'(1);
                        end
                    end else if (c == CH_RBRK) begin
                        n_bracket = r_bracket - DEPTH_BITS'(1);
                        if (n_bracket == '0) begin
                            n_phase = PH_AFTER_BRACKET;
                        end
                    end
                end
                PH_AFTER_BRACKET: begin
                    if (c == CH_LBRACE) begin
                        n_brace  = DEPTH_BITS'(1);
                        n_tstart = col_inc;
                        n_sat    = r_sat | col_full;
                        n_phase  = PH_TITLE;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_TITLE: begin
                    if (c == CH_RBRACE) begin
                        n_brace = r_brace - DEPTH_BITS'(1);
                        if (n_brace == '0) begin
                            // closing brace: report with values before this byte
                            o_emit  = (r_tcount != '0);
                            n_phase = PH_IDLE;
                        end else begin
                            n_tcount = tc_inc;
                            n_sat    = r_sat | tc_full;
                        end
                    end else begin
                        if (c == CH_LBRACE) begin
                            if (&r_brace) begin
                                n_sat = 1'b1;
                            end else begin
                                n_brace = r_brace + DEPTH_BITS'(1);
                            end
                        end
                        n_tcount = tc_inc;
                        n_sat    = n_sat | tc_full;
                    end
                end
                default: begin
                end
            endcase

            n_col = col_inc;
            n_sat = n_sat | col_full;

            // end of text inside an open title
            if (i_word.last_of_text && n_phase == PH_TITLE && n_tcount != '0 && !o_emit) begin
                o_emit         = 1'b1;
                o_unterminated = 1'b1;
                o_level        = n_level;
                o_title_column = n_tstart;
                o_title_length = n_tcount;
                o_overlong     = n_sat;
            end
        end

        if (i_word.last_of_text) begin
            n_phase   = PH_LEAD;
            n_cand    = '1;
            n_pos     = '0;
            n_star    = 1'b0;
            n_bracket = '0;
            n_brace   = '0;
            n_col     = '0;
            n_tstart  = '0;
            n_tcount  = '0;
            n_level   = '0;
            n_sat     = 1'b0;
            n_line    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEAD;
            r_cand    <= '1;
            r_pos     <= '0;
            r_star    <= 1'b0;
            r_bracket <= '0;
            r_brace   <= '0;
            r_col     <= '0;
            r_tstart  <= '0;
            r_tcount  <= '0;
            r_line    <= '0;
            r_level   <= '0;
            r_sat     <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_cand    <= n_cand;
            r_pos     <= n_pos;
            r_star    <= n_star;
            r_bracket <= n_bracket;
            r_brace   <= n_brace;
            r_col     <= n_col;
            r_tstart  <= n_tstart;
            r_tcount  <= n_tcount;
            r_line    <= n_line;
            r_level   <= n_level;
            r_sat     <= n_sat;
        end
    end

endmodule

### src/latex_heading_scanner_unit.sv
// ----------------------------------------------------------------------------
// latex_heading_scanner_unit
// Byte-stream scanner that reports sectioning headings found in document text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one text byte per word (i_text_byte, i_last_of_text),
//   qualified by i_in_valid and held off by o_in_stall. Newline ends a line;
//   the word with i_last_of_text set ends the text and clears the line count.
//   Output channel: at most one heading word per input word, qualified by
//   o_out_valid and held by i_out_stall.
//   Throughput: one input word per cycle while no result waits under
//   i_out_stall. An accepted word is loaded into the input register, scanned
//   from there, and any heading is registered in the result register, which
//   drives o_out_valid. The rate is set by the scan state, updated once per word.
//   Stall: while a result waits under i_out_stall, the word in the input
//   register is held and o_in_stall rises once that register is occupied.
//   Reset: synchronous, active low; clears both registers' valid flags, the
//   scan state and the line count.
// ----------------------------------------------------------------------------
module latex_heading_scanner_unit #(
    parameter int unsigned LINE_BITS  = lhs_pkg::LINE_BITS_DEF,
    parameter int unsigned COL_BITS   = lhs_pkg::COL_BITS_DEF,
    parameter int unsigned DEPTH_BITS = lhs_pkg::DEPTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_last_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_level,
    output logic [LINE_BITS-1:0]  o_line_number,
    output logic [COL_BITS-1:0]   o_title_column,
    output logic [COL_BITS-1:0]   o_title_length,
    output logic                  o_unterminated,
    output logic                  o_overlong
);
    import lhs_pkg::*;

    logic                 r_in_valid;
    t_in_word             r_in_word;
    logic                 r_out_valid;
    logic [2:0]           r_level;
    logic [LINE_BITS-1:0] r_line;
    logic [COL_BITS-1:0]  r_tcol;
    logic [COL_BITS-1:0]  r_tlen;
    logic                 r_unterm;
    logic                 r_over;

    logic                 adv;
    logic                 fire;
    logic                 emit;
    logic [2:0]           s_level;
    logic [LINE_BITS-1:0] s_line;
    logic [COL_BITS-1:0]  s_tcol;
    logic [COL_BITS-1:0]  s_tlen;
    logic                 s_unterm;
    logic                 s_over;

    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= '{text_byte: i_text_byte, last_of_text: i_last_of_text};
        end
    end

    lhs_scan #(
        .LINE_BITS  (LINE_BITS),
        .COL_BITS   (COL_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_word         (r_in_word),
        .o_emit         (emit),
        .o_level        (s_level),
        .o_line_number  (s_line),
        .o_title_column (s_tcol),
        .o_title_length (s_tlen),
        .o_unterminated (s_unterm),
        .o_overlong     (s_over)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_level  <= s_level;
            r_line   <= s_line;
            r_tcol   <= s_tcol;
            r_tlen   <= s_tlen;
            r_unterm <= s_unterm;
            r_over   <= s_over;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_level        = r_level;
    assign o_line_number  = r_line;
    assign o_title_column = r_tcol;
    assign o_title_length = r_tlen;
    assign o_unterminated = r_unterm;
    assign o_overlong     = r_over;

endmodule

### src/lhs_checker.sv
// ----------------------------------------------------------------------------
// lhs_checker
// Port-level checks for the heading scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lhs_checker #(
    parameter int unsigned LINE_BITS = lhs_pkg::LINE_BITS_DEF,
    parameter int unsigned COL_BITS  = lhs_pkg::COL_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [2:0]           o_level,
    input logic [LINE_BITS-1:0] o_line_number,
    input logic [COL_BITS-1:0]  o_title_column,
    input logic [COL_BITS-1:0]  o_title_length
);

    // stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_level)
            && $stable(o_line_number) && $stable(o_title_column)
            && $stable(o_title_length))
        else $error("stalled result word changed");

    // input side only backs up when the output side is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_title_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_title_length != '0)
        else $error("empty title reported");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level == 3'd0 || o_level == 3'd1 || o_level == 3'd2
            || o_level == 3'd3 || o_level == 3'd4 || o_level == 3'd5))
        else $error("heading level out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

endmodule

bind latex_heading_scanner_unit lhs_checker #(
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS)
) u_lhs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_level        (o_level),
    .o_line_number  (o_line_number),
    .o_title_column (o_title_column),
    .o_title_length (o_title_length)
);
